[hw/rtl/ceacc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ceacc_pkg
// Shared constants, types and command/status bundles of the character
// energy accumulator.
// ----------------------------------------------------------------------------
package ceacc_pkg;

  localparam int MAX_PIXELS_DEFAULT = 4096;

  localparam int ANGLE_W = 15;
  localparam int THR_W   = 14;
  localparam int SUM_W   = 26;
  localparam int CNT_W   = 13;
  localparam int MEAN_W  = 14;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = 27;   // count * pi

  localparam int COUNT_LIMIT = 8191;

  localparam logic [THR_W-1:0]   THR_RESET = 14'd7721;
  localparam logic [13:0]        PI_Q      = 14'd12868;
  localparam logic [14:0]        TWO_PI_Q  = 15'd25736;
  localparam logic signed [14:0] ANGLE_PI  = 15'sd12868;

  // divider geometry
  localparam int DVD_W  = 44;
  localparam int DVS_W  = 28;
  localparam int QUO_W  = 17;
  localparam int STEP_W = 6;

  localparam int MEAN_DVD_W = 27;
  localparam int FRAC_DVD_W = 29;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_FRAC,
    DIV_ENERGY
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     accumulate;
    logic     prep;
    logic     div_load;
    logic     div_step;
    logic     store;
    logic     finish;
    div_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic cap_last;
    logic n_zero;
    logic div_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[hw/rtl/ceacc_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ceacc_div
// Restoring divider, one quotient bit per cycle while step is high,
// left-aligned dividend, overflow flag for quotient bits shifted out.
// ----------------------------------------------------------------------------
module ceacc_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire logic                         step,
  input  wire logic [ceacc_pkg::DVD_W-1:0]  dividend,
  input  wire logic [ceacc_pkg::DVS_W-1:0]  divisor,
  input  wire logic [ceacc_pkg::STEP_W-1:0] steps,
  output logic      [ceacc_pkg::QUO_W-1:0]  quotient,
  output logic                              overflow,
  output logic                              last
);

  logic [ceacc_pkg::DVD_W-1:0]  dvd;
  logic [ceacc_pkg::DVS_W-1:0]  dvs;
  logic [ceacc_pkg::DVS_W-1:0]  rem;
  logic [ceacc_pkg::STEP_W-1:0] cnt;
  logic [ceacc_pkg::DVS_W:0]    rem_sh;
  logic [ceacc_pkg::DVS_W:0]    rem_sub;
  logic                         qbit;

  always_comb begin
    rem_sh  = {rem, dvd[ceacc_pkg::DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    qbit    = (rem_sh >= {1'b0, dvs});
  end

  assign last = (cnt == ceacc_pkg::STEP_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= steps;
    end else if (step) begin
      cnt <= cnt - ceacc_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
      overflow <= 1'b0;
    end else if (step) begin
      dvd      <= {dvd[ceacc_pkg::DVD_W-2:0], 1'b0};
      rem      <= qbit ? rem_sub[ceacc_pkg::DVS_W-1:0] : rem_sh[ceacc_pkg::DVS_W-1:0];
      quotient <= {quotient[ceacc_pkg::QUO_W-2:0], qbit};
      overflow <= overflow | quotient[ceacc_pkg::QUO_W-1];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ceacc_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ceacc_dp
// Datapath: input capture, angle difference accumulation, dividend setup,
// shared divider, result and output registers.
// ----------------------------------------------------------------------------
module ceacc_dp #(
  parameter int MAX_PIXELS = ceacc_pkg::MAX_PIXELS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire ceacc_pkg::cmd_t                     cmd,
  output ceacc_pkg::status_t                       status,
  input  wire logic                                cfg_wr_en,
  input  wire logic        [ceacc_pkg::THR_W-1:0]  cfg_wr_data,
  input  wire logic signed [ceacc_pkg::ANGLE_W-1:0] edge_angle,
  input  wire logic signed [ceacc_pkg::ANGLE_W-1:0] pair_angle,
  input  wire logic                                pair_found,
  input  wire logic                                last_pixel,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     result_valid,
  output logic             [ceacc_pkg::MEAN_W-1:0] mean_difference,
  output logic             [ceacc_pkg::FRAC_W-1:0] opposite_fraction,
  output logic             [ceacc_pkg::FRAC_W-1:0] char_energy
);

  localparam int CAP = (MAX_PIXELS > ceacc_pkg::COUNT_LIMIT) ?
                       ceacc_pkg::COUNT_LIMIT : MAX_PIXELS;
  localparam logic [ceacc_pkg::CNT_W-1:0] CAP_N = ceacc_pkg::CNT_W'(CAP);

  logic [ceacc_pkg::THR_W-1:0]  threshold;
  logic signed [ceacc_pkg::ANGLE_W:0] diff;
  logic                         in_range;
  logic                         cap_pair;
  logic                         cap_last;

  logic [ceacc_pkg::SUM_W-1:0]  sum;
  logic [ceacc_pkg::CNT_W-1:0]  opp;
  logic [ceacc_pkg::CNT_W-1:0]  cnt;
  logic [ceacc_pkg::PROD_W-1:0] prod_o;
  logic [ceacc_pkg::PROD_W-1:0] prod_n;

  logic [ceacc_pkg::MEAN_W-1:0] res_mean;
  logic [ceacc_pkg::FRAC_W-1:0] res_frac;
  logic [ceacc_pkg::FRAC_W-1:0] res_energy;

  logic [ceacc_pkg::ANGLE_W-1:0] d_abs;
  logic [ceacc_pkg::THR_W-1:0]   d_wrap;
  logic [ceacc_pkg::SUM_W:0]     sum_wide;
  logic                          acc_en;

  logic [ceacc_pkg::MEAN_DVD_W-1:0] mean_dvd;
  logic [ceacc_pkg::FRAC_DVD_W-1:0] frac_dvd;
  logic [ceacc_pkg::DVS_W-1:0]      num_hi;
  logic [ceacc_pkg::DVD_W-1:0]      div_dividend;
  logic [ceacc_pkg::DVS_W-1:0]      div_divisor;
  logic [ceacc_pkg::STEP_W-1:0]     div_steps;
  logic [ceacc_pkg::QUO_W-1:0]      quo;
  logic                             quo_ovf;
  logic                             div_last;

  // ---- accumulation ----
  always_comb begin
    d_abs    = diff[ceacc_pkg::ANGLE_W] ? ceacc_pkg::ANGLE_W'(-diff)
                                        : diff[ceacc_pkg::ANGLE_W-1:0];
    d_wrap   = (d_abs > 15'(ceacc_pkg::PI_Q)) ? 14'(ceacc_pkg::TWO_PI_Q - d_abs)
                                              : d_abs[ceacc_pkg::THR_W-1:0];
    sum_wide = {1'b0, sum} + 27'(d_wrap);
    acc_en   = cmd.accumulate && cap_pair && (cnt < CAP_N);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ceacc_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      diff     <= {edge_angle[ceacc_pkg::ANGLE_W-1], edge_angle}
                - {pair_angle[ceacc_pkg::ANGLE_W-1], pair_angle};
      in_range <= (edge_angle >= -ceacc_pkg::ANGLE_PI) && (edge_angle <= ceacc_pkg::ANGLE_PI)
               && (pair_angle >= -ceacc_pkg::ANGLE_PI) && (pair_angle <= ceacc_pkg::ANGLE_PI);
      cap_pair <= pair_found;
      cap_last <= last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      opp <= '0;
      cnt <= '0;
    end else if (cmd.finish) begin
      sum <= '0;
      opp <= '0;
      cnt <= '0;
    end else if (acc_en) begin
      cnt <= cnt + ceacc_pkg::CNT_W'(1);
      if (in_range) begin
        sum <= sum_wide[ceacc_pkg::SUM_W] ? '1 : sum_wide[ceacc_pkg::SUM_W-1:0];
        if (d_wrap >= threshold) begin
          opp <= opp + ceacc_pkg::CNT_W'(1);
        end
      end
    end
  end

  // ---- division setup ----
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      prod_o <= ceacc_pkg::PROD_W'(opp) * ceacc_pkg::PROD_W'(ceacc_pkg::PI_Q);
      prod_n <= ceacc_pkg::PROD_W'(cnt) * ceacc_pkg::PROD_W'(ceacc_pkg::PI_Q);
    end
  end

  always_comb begin
    mean_dvd = ceacc_pkg::MEAN_DVD_W'(sum) + ceacc_pkg::MEAN_DVD_W'(cnt >> 1);
    frac_dvd = {opp, 16'b0} + ceacc_pkg::FRAC_DVD_W'(cnt >> 1);
    num_hi   = ceacc_pkg::DVS_W'(sum) + ceacc_pkg::DVS_W'(prod_o);
    unique case (cmd.sel)
      ceacc_pkg::DIV_MEAN: begin
        div_dividend = {mean_dvd, {(ceacc_pkg::DVD_W-ceacc_pkg::MEAN_DVD_W){1'b0}}};
        div_divisor  = ceacc_pkg::DVS_W'(cnt);
        div_steps    = ceacc_pkg::STEP_W'(ceacc_pkg::MEAN_DVD_W);
      end
      ceacc_pkg::DIV_FRAC: begin
        div_dividend = {frac_dvd, {(ceacc_pkg::DVD_W-ceacc_pkg::FRAC_DVD_W){1'b0}}};
        div_divisor  = ceacc_pkg::DVS_W'(cnt);
        div_steps    = ceacc_pkg::STEP_W'(ceacc_pkg::FRAC_DVD_W);
      end
      ceacc_pkg::DIV_ENERGY: begin
        // (sum + opp*pi) * 65536 + n*pi over 2*n*pi
        div_dividend = {num_hi, 16'b0} + ceacc_pkg::DVD_W'(prod_n);
        div_divisor  = {prod_n, 1'b0};
        div_steps    = ceacc_pkg::STEP_W'(ceacc_pkg::DVD_W);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
        div_steps    = '0;
      end
    endcase
  end

  ceacc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .quotient (quo),
    .overflow (quo_ovf),
    .last     (div_last)
  );

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.sel)
        ceacc_pkg::DIV_MEAN:
          res_mean <= (quo_ovf || quo > 17'h03FFF) ? '1 : quo[ceacc_pkg::MEAN_W-1:0];
        ceacc_pkg::DIV_FRAC:
          res_frac <= (quo_ovf || quo[ceacc_pkg::QUO_W-1]) ? '1 : quo[ceacc_pkg::FRAC_W-1:0];
        default:
          res_energy <= (quo_ovf || quo[ceacc_pkg::QUO_W-1]) ? '1 : quo[ceacc_pkg::FRAC_W-1:0];
      endcase
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result_valid      <= (cnt != '0);
      mean_difference   <= (cnt != '0) ? res_mean   : '0;
      opposite_fraction <= (cnt != '0) ? res_frac   : '0;
      char_energy       <= (cnt != '0) ? res_energy : '0;
    end
  end

  always_comb begin
    status.cap_last = cap_last;
    status.n_zero   = (cnt == '0);
    status.div_last = div_last;
    status.out_free = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

[hw/rtl/ceacc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ceacc_ctrl
// Controller: sequences request capture, accumulation, the three
// end-of-object divisions (none for an empty object) and the output hand-off.
// ----------------------------------------------------------------------------
module ceacc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ceacc_pkg::status_t status,
  output ceacc_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_PREP,
    ST_LOAD,
    ST_RUN,
    ST_STORE,
    ST_FINISH
  } state_t;

  state_t               state;
  ceacc_pkg::div_sel_t  sel;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.sel        = sel;
    cmd.capture    = (state == ST_IDLE) && in_valid;
    cmd.accumulate = (state == ST_ACC);
    cmd.prep       = (state == ST_PREP);
    cmd.div_load   = (state == ST_LOAD);
    cmd.div_step   = (state == ST_RUN);
    cmd.store      = (state == ST_STORE);
    cmd.finish     = (state == ST_FINISH) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= ceacc_pkg::DIV_MEAN;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_ACC;
        end
        ST_ACC: begin
          state <= status.cap_last ? ST_PREP : ST_IDLE;
        end
        ST_PREP: begin
          sel   <= ceacc_pkg::DIV_MEAN;
          state <= status.n_zero ? ST_FINISH : ST_LOAD;
        end
        ST_LOAD: begin
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (status.div_last) state <= ST_STORE;
        end
        ST_STORE: begin
          unique case (sel)
            ceacc_pkg::DIV_MEAN: begin
              sel   <= ceacc_pkg::DIV_FRAC;
              state <= ST_LOAD;
            end
            ceacc_pkg::DIV_FRAC: begin
              sel   <= ceacc_pkg::DIV_ENERGY;
              state <= ST_LOAD;
            end
            default: begin
              state <= ST_FINISH;
            end
          endcase
        end
        ST_FINISH: begin
          if (status.out_free) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/character_energy_accumulator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// character_energy_accumulator_top
// Accumulates wrapped gradient direction differences over an object's
// contour pixels and reports mean difference, opposite fraction and energy.
// ----------------------------------------------------------------------------
// An ordinary pixel request is captured, then accumulated in one adder pass.
// When the object had paired pixels, the request marked last_pixel also runs
// three divisions one after another on a single shared restoring divider, one
// quotient bit per cycle (27, 29 and 44 bits, plus load and store steps).
// Without paired pixels the divisions are skipped. The result sits in an
// output register; the block keeps taking pixels while it waits, and only
// holds at the end of the next object if that result is still stalled.
// opposite_threshold may be written at any idle time.
// ----------------------------------------------------------------------------
module character_energy_accumulator_top #(
  parameter int MAX_PIXELS = ceacc_pkg::MAX_PIXELS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic        [ceacc_pkg::THR_W-1:0]   cfg_wr_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [ceacc_pkg::ANGLE_W-1:0] edge_angle,
  input  wire logic signed [ceacc_pkg::ANGLE_W-1:0] pair_angle,
  input  wire logic                                 pair_found,
  input  wire logic                                 last_pixel,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      result_valid,
  output logic             [ceacc_pkg::MEAN_W-1:0]  mean_difference,
  output logic             [ceacc_pkg::FRAC_W-1:0]  opposite_fraction,
  output logic             [ceacc_pkg::FRAC_W-1:0]  char_energy
);

  ceacc_pkg::cmd_t    cmd;
  ceacc_pkg::status_t status;

  ceacc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ceacc_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .edge_angle        (edge_angle),
    .pair_angle        (pair_angle),
    .pair_found        (pair_found),
    .last_pixel        (last_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .result_valid      (result_valid),
    .mean_difference   (mean_difference),
    .opposite_fraction (opposite_fraction),
    .char_energy       (char_energy)
  );

`ifndef NO_ASSERTIONS
  // an accepted request always occupies the accumulate cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted on back-to-back cycles");

  // mean of wrapped differences never exceeds pi
  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mean_difference <= ceacc_pkg::MEAN_W'(ceacc_pkg::PI_Q)))
    else $error("mean difference above pi");

  // an empty object reports all zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_valid) |->
      (mean_difference == '0 && opposite_fraction == '0 && char_energy == '0))
    else $error("empty object reported nonzero fields");

  // a new result is loaded only while the input side is held off
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> in_stall)
    else $error("result loaded while accepting requests");
`endif

endmodule
`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: character energy accumulator regression
// Drives contour pixel requests with random gaps and output stalls. A local
// model of the accumulators predicts each object's summary, and the monitor
// compares every summary, field by field, in arrival order. The opposite
// threshold is rewritten between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PI_INT      = int'(ceacc_pkg::PI_Q);
  localparam int TWO_PI_INT  = int'(ceacc_pkg::TWO_PI_Q);
  localparam int PIXEL_CAP   = (ceacc_pkg::MAX_PIXELS_DEFAULT > ceacc_pkg::COUNT_LIMIT) ?
                               ceacc_pkg::COUNT_LIMIT : ceacc_pkg::MAX_PIXELS_DEFAULT;
  localparam int SUM_MAX     = (1 << ceacc_pkg::SUM_W) - 1;
  localparam int SETTLE      = 150;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic signed [ceacc_pkg::ANGLE_W-1:0] edge_ang;
    logic signed [ceacc_pkg::ANGLE_W-1:0] pair_ang;
    logic                                 found;
    logic                                 last;
  } pixel_t;

  typedef struct {
    logic                         valid;
    logic [ceacc_pkg::MEAN_W-1:0] mean;
    logic [ceacc_pkg::FRAC_W-1:0] frac;
    logic [ceacc_pkg::FRAC_W-1:0] energy;
  } summary_t;

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 cfg_wr_en;
  logic [ceacc_pkg::THR_W-1:0]          cfg_wr_data;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [ceacc_pkg::ANGLE_W-1:0] edge_angle = '0;
  logic signed [ceacc_pkg::ANGLE_W-1:0] pair_angle = '0;
  logic                                 pair_found = 1'b0;
  logic                                 last_pixel = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic                                 result_valid;
  logic [ceacc_pkg::MEAN_W-1:0]         mean_difference;
  logic [ceacc_pkg::FRAC_W-1:0]         opposite_fraction;
  logic [ceacc_pkg::FRAC_W-1:0]         char_energy;

  pixel_t   pixel_q[$];
  summary_t summary_q[$];
  pixel_t   drive_px;

  // model state
  logic [ceacc_pkg::THR_W-1:0] opp_threshold = ceacc_pkg::THR_RESET;
  int unsigned                 diff_sum      = 0;
  int unsigned                 opp_count     = 0;
  int unsigned                 paired_count  = 0;

  bit in_fire     = 1'b0;
  bit failed      = 1'b0;
  int cycle_count = 0;

  character_energy_accumulator_top u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .edge_angle        (edge_angle),
    .pair_angle        (pair_angle),
    .pair_found        (pair_found),
    .last_pixel        (last_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .result_valid      (result_valid),
    .mean_difference   (mean_difference),
    .opposite_fraction (opposite_fraction),
    .char_energy       (char_energy)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // long stretches with no idling on either side
  function automatic bit take_break();
    return ((cycle_count % 3000) >= 700) && ($urandom_range(99) < 16);
  endfunction

  task automatic queue_pixel(input pixel_t px);
    pixel_q.insert(pixel_q.size(), px);
  endtask

  // Folds one accepted pixel into the model; the last pixel closes the object.
  task automatic fold_pixel(input pixel_t px);
    int a, b, d;
    longint unsigned n, s, o, num, den, q;
    summary_t r;
    a = px.edge_ang;
    b = px.pair_ang;
    if (px.found && paired_count < PIXEL_CAP) begin
      if (a >= -PI_INT && a <= PI_INT && b >= -PI_INT && b <= PI_INT) begin
        d = (a > b) ? a - b : b - a;
        if (d > PI_INT) d = TWO_PI_INT - d;
        diff_sum = (diff_sum + d > SUM_MAX) ? SUM_MAX : diff_sum + d;
        if (d >= int'(opp_threshold)) opp_count++;
      end
      paired_count++;
    end
    if (!px.last) return;
    r = '{valid: 1'b0, mean: '0, frac: '0, energy: '0};
    if (paired_count > 0) begin
      n = paired_count;
      s = diff_sum;
      o = opp_count;
      r.valid = 1'b1;
      q = (s + n / 2) / n;
      r.mean = (q > 64'h3FFF) ? '1 : q[ceacc_pkg::MEAN_W-1:0];
      q = ((o << 16) + n / 2) / n;
      r.frac = (q > 64'hFFFF) ? '1 : q[ceacc_pkg::FRAC_W-1:0];
      num = (s << 16) + (o << 16) * PI_INT;
      den = 2 * n * PI_INT;
      q = (num + den / 2) / den;
      r.energy = (q > 64'hFFFF) ? '1 : q[ceacc_pkg::FRAC_W-1:0];
    end
    summary_q.insert(summary_q.size(), r);
    diff_sum = 0;
    opp_count = 0;
    paired_count = 0;
  endtask

  // monitor: requests in, summaries out
  always @(posedge clk) begin
    summary_t exp_r;
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire)
      fold_pixel('{edge_ang: edge_angle, pair_ang: pair_angle,
                   found: pair_found, last: last_pixel});
    if (!rst && out_valid && !out_stall) begin
      if (summary_q.size() == 0) begin
        $error("unexpected summary: result_valid %0d mean %0d frac %0d energy %0d",
               result_valid, mean_difference, opposite_fraction, char_energy);
        failed = 1'b1;
      end else begin
        exp_r = summary_q.pop_front();
        if (result_valid !== exp_r.valid) begin
          $error("result_valid: expected %0d actual %0d", exp_r.valid, result_valid);
          failed = 1'b1;
        end
        if (mean_difference !== exp_r.mean) begin
          $error("mean_difference: expected %0d actual %0d", exp_r.mean, mean_difference);
          failed = 1'b1;
        end
        if (opposite_fraction !== exp_r.frac) begin
          $error("opposite_fraction: expected %0d actual %0d", exp_r.frac,
                 opposite_fraction);
          failed = 1'b1;
        end
        if (char_energy !== exp_r.energy) begin
          $error("char_energy: expected %0d actual %0d", exp_r.energy, char_energy);
          failed = 1'b1;
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // stalled request holds
    end else if (pixel_q.size() != 0 && !take_break()) begin
      drive_px = pixel_q.pop_front();
      in_valid   <= 1'b1;
      edge_angle <= drive_px.edge_ang;
      pair_angle <= drive_px.pair_ang;
      pair_found <= drive_px.found;
      last_pixel <= drive_px.last;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_stall <= take_break();
  end

  function automatic pixel_t make_pixel(input int e, input int p, input bit f, input bit l);
    pixel_t px;
    px.edge_ang = e[ceacc_pkg::ANGLE_W-1:0];
    px.pair_ang = p[ceacc_pkg::ANGLE_W-1:0];
    px.found    = f;
    px.last     = l;
    return px;
  endfunction

  // Random objects; only paired pixels count toward the budget.
  task automatic add_objects(input int budget);
    int paired, len, e, p, d, pick;
    bit f;
    paired = 0;
    while (paired < budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(80, 13) : $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
        f = ($urandom_range(99) < 82);
        pick = $urandom_range(99);
        if (pick < 8) begin
          // anywhere in the 15-bit range, often outside +/- pi
          e = $urandom_range(32767) - 16384;
          p = $urandom_range(32767) - 16384;
        end else if (pick < 30) begin
          // land on or next to the threshold, directly or through the wrap
          d = int'(opp_threshold) + $urandom_range(4) - 2;
          if (d < 0) d = 0;
          if (d > PI_INT) d = PI_INT;
          if ($urandom_range(1)) d = TWO_PI_INT - d;
          e = $urandom_range(TWO_PI_INT) - PI_INT;
          p = e - d;
          if (p < -PI_INT) p = e + d;
        end else begin
          e = $urandom_range(TWO_PI_INT) - PI_INT;
          p = $urandom_range(TWO_PI_INT) - PI_INT;
        end
        queue_pixel(make_pixel(e, p, f, i == len - 1));
        if (f) paired++;
      end
    end
  endtask

  task automatic settle_idle();
    while (pixel_q.size() != 0 || in_valid || summary_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [ceacc_pkg::THR_W-1:0] thr);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= thr;
    opp_threshold = thr;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, threshold at its reset value
    queue_pixel(make_pixel(0, 0, 0, 1));             // empty object
    queue_pixel(make_pixel(12868, -12868, 1, 0));    // wraps to zero
    queue_pixel(make_pixel(-12868, 12868, 1, 0));
    queue_pixel(make_pixel(12868, 0, 1, 0));         // exactly pi
    queue_pixel(make_pixel(0, 0, 1, 0));
    queue_pixel(make_pixel(-16384, 16383, 1, 0));    // out of range, counted
    queue_pixel(make_pixel(12869, 0, 1, 0));
    queue_pixel(make_pixel(0, -12869, 1, 0));
    queue_pixel(make_pixel(16383, -16384, 0, 0));    // unpaired junk
    queue_pixel(make_pixel(7721, 0, 1, 0));          // difference equals threshold
    queue_pixel(make_pixel(0, 7720, 1, 1));          // one below
    queue_pixel(make_pixel(5, 5, 1, 0));
    queue_pixel(make_pixel(-1, -1, 0, 1));           // unpaired last pixel
    queue_pixel(make_pixel(16383, 0, 1, 1));         // only out-of-range pairs
    queue_pixel(make_pixel(-12868, 12867, 1, 1));    // wraps to one
    add_objects(120);
    settle_idle();

    // every difference is opposite; mean pi saturates the energy
    write_threshold(14'd0);
    queue_pixel(make_pixel(12868, 0, 1, 0));
    queue_pixel(make_pixel(-12868, 0, 1, 1));
    add_objects(160);
    settle_idle();

    write_threshold(14'h3FFF);
    add_objects(140);
    settle_idle();

    write_threshold(ceacc_pkg::PI_Q);
    queue_pixel(make_pixel(6434, -6434, 1, 1));
    add_objects(140);
    settle_idle();

    write_threshold(ceacc_pkg::PI_Q + 14'd1);
    add_objects(120);
    settle_idle();

    repeat (2) begin
      write_threshold(ceacc_pkg::THR_W'($urandom_range(PI_INT)));
      add_objects(180);
      settle_idle();
    end

    if (!failed && summary_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/ceacc_pkg.sv
hw/rtl/ceacc_div.sv
hw/rtl/ceacc_dp.sv
hw/rtl/ceacc_ctrl.sv
hw/rtl/character_energy_accumulator_top.sv
dv/tb_top.sv
